[rtl/core/vdrh_pkg.sv]
package vdrh_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_BINS_DEF  = 64;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int FRAC_BITS_DEF = 4;

    // Fixed field widths.
    localparam int DISP_W = 10;
    localparam int MAXD_W = 7;
    localparam logic [MAXD_W-1:0] MAXD_RESET = 7'd64;

    // Queue between the classifier and the histogram engine.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = QAW + 1;

endpackage

[rtl/core/vdrh_ram.sv]
module vdrh_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Single write port and one registered read port; a read and a write to the
    // same address in one cycle return the old contents.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/vdrh_front.sv]
module vdrh_front #(
    parameter int NUM_BINS  = vdrh_pkg::NUM_BINS_DEF,
    parameter int FRAC_BITS = vdrh_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Pixel request channel.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [vdrh_pkg::DISP_W-1:0]   i_disparity_q4,
    input  logic                          i_end_of_row,
    // Active bin count at this pixel and clearing status from the back end.
    input  logic [$clog2(NUM_BINS+1)-1:0] i_lim,
    input  logic                          i_init,
    // Classified pixels toward the histogram engine.
    output logic                          o_q_valid,
    input  logic                          i_q_pop,
    output logic [$clog2(NUM_BINS)-1:0]   o_q_bin,
    output logic                          o_q_ok,
    output logic                          o_q_eor,
    output logic [$clog2(NUM_BINS+1)-1:0] o_q_lim
);

    import vdrh_pkg::*;

    localparam int IW   = $clog2(NUM_BINS);
    localparam int LW   = $clog2(NUM_BINS + 1);
    localparam int SW   = DISP_W + 1;
    localparam int CMPW = (LW > SW) ? LW : SW;
    localparam logic [SW-1:0] HALF = SW'((1 << FRAC_BITS) >> 1);

    logic [SW-1:0] sum;
    logic [SW-1:0] bin_full;
    logic          bin_ok;
    logic          push;

    logic [IW-1:0]  r_q_bin [QDEPTH];
    logic           r_q_ok  [QDEPTH];
    logic           r_q_eor [QDEPTH];
    logic [LW-1:0]  r_q_lim [QDEPTH];
    logic [QAW-1:0] r_wptr, n_wptr;
    logic [QAW-1:0] r_rptr, n_rptr;
    logic [QCW-1:0] r_cnt, n_cnt;

    // Round to the nearest bin, halves up, and keep nonzero bins below the limit.
    always_comb begin
        sum      = SW'(i_disparity_q4) + HALF;
        bin_full = sum >> FRAC_BITS;
        bin_ok   = (bin_full != '0) && (CMPW'(bin_full) < CMPW'(i_lim));
    end

    // The queue accepts while it has room and the store is not being cleared.
    assign o_stall = (r_cnt == QCW'(QDEPTH)) || i_init;
    assign push    = i_valid && !o_stall;

    always_comb begin
        n_wptr = push ? r_wptr + QAW'(1) : r_wptr;
        n_rptr = i_q_pop ? r_rptr + QAW'(1) : r_rptr;
        n_cnt  = r_cnt + QCW'(push) - QCW'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_bin[r_wptr] <= bin_full[IW-1:0];
            r_q_ok[r_wptr]  <= bin_ok;
            r_q_eor[r_wptr] <= i_end_of_row;
            r_q_lim[r_wptr] <= i_lim;
        end
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_q_bin   = r_q_bin[r_rptr];
    assign o_q_ok    = r_q_ok[r_rptr];
    assign o_q_eor   = r_q_eor[r_rptr];
    assign o_q_lim   = r_q_lim[r_rptr];

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(QDEPTH))
        else $error("queue fill exceeds its depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_cnt != '0)
        else $error("pop from an empty queue");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && r_cnt != QCW'(QDEPTH)) |-> r_wptr != r_rptr)
        else $error("queue pointers disagree with the fill count");
`endif

endmodule

[rtl/core/vdrh_back.sv]
module vdrh_back #(
    parameter int NUM_BINS  = vdrh_pkg::NUM_BINS_DEF,
    parameter int MAX_WIDTH = vdrh_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Classified pixels from the front end.
    input  logic                             i_q_valid,
    output logic                             o_q_pop,
    input  logic [$clog2(NUM_BINS)-1:0]      i_q_bin,
    input  logic                             i_q_ok,
    input  logic                             i_q_eor,
    input  logic [$clog2(NUM_BINS+1)-1:0]    i_q_lim,
    // High during the clearing sweep after reset.
    output logic                             o_init,
    // Bin request channel.
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [$clog2(NUM_BINS)-1:0]      o_bin_index,
    output logic [$clog2(MAX_WIDTH+1)-1:0]   o_bin_count,
    output logic                             o_last_bin
);

    import vdrh_pkg::*;

    localparam int IW = $clog2(NUM_BINS);
    localparam int LW = $clog2(NUM_BINS + 1);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam logic [IW-1:0] K_LAST = IW'(NUM_BINS - 1);
    localparam logic [CW-1:0] SAT    = CW'(MAX_WIDTH);

    typedef enum logic [2:0] {
        S_COUNT = 3'b001,
        S_WAIT  = 3'b010,
        S_DUMP  = 3'b100
    } t_back_state;

    t_back_state   r_state, n_state;
    logic [IW-1:0] r_k, n_k;
    logic [LW-1:0] r_lim, n_lim;
    logic          r_init, n_init;

    // Update stage and the write it forwards from.
    logic          r_b_valid;
    logic [IW-1:0] r_b_addr;
    logic          r_lw_valid;
    logic [IW-1:0] r_lw_addr;
    logic [CW-1:0] r_lw_data;

    // Readout: one read in flight and the output register.
    logic          r_pend;
    logic [IW-1:0] r_pend_k;
    logic          r_pend_last;
    logic          r_o_valid;
    logic [IW-1:0] r_o_index;
    logic [CW-1:0] r_o_count;
    logic          r_o_last;

    logic          cnt_rd;
    logic          cnt_we;
    logic [CW-1:0] base;
    logic [CW-1:0] incr;
    logic          in_range;
    logic          can_issue;
    logic          dump_step;
    logic          dump_rd;
    logic          k_last_hit;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [CW-1:0] ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [CW-1:0] ram_rdata;

    // Counting: read the bin when an in-range pixel is popped, add one in the next cycle with forwarding.
    always_comb begin
        o_q_pop = (r_state == S_COUNT) && i_q_valid;
        cnt_rd  = o_q_pop && i_q_ok;
        cnt_we  = r_b_valid;
        base    = (r_lw_valid && (r_lw_addr == r_b_addr)) ? r_lw_data : ram_rdata;
        incr    = (base < SAT) ? base + CW'(1) : base;
    end

    // Readout sweep: reported bins wait for a free output slot, the rest only clear.
    always_comb begin
        in_range   = (LW'(r_k) < r_lim);
        can_issue  = !r_pend && (!r_o_valid || !i_stall);
        dump_step  = (r_state == S_DUMP) && (!in_range || can_issue);
        dump_rd    = (r_state == S_DUMP) && in_range && can_issue;
        k_last_hit = (r_k == K_LAST);
    end

    // Memory port sharing between counting and the sweep.
    always_comb begin
        ram_we    = cnt_we || dump_step;
        ram_waddr = cnt_we ? r_b_addr : r_k;
        ram_wdata = cnt_we ? incr : '0;
        ram_re    = cnt_rd || dump_rd;
        ram_raddr = cnt_rd ? i_q_bin : r_k;
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_lim   = r_lim;
        n_init  = r_init;
        case (r_state)
            S_COUNT: begin
                if (o_q_pop && i_q_eor) begin
                    n_state = S_WAIT;
                    n_lim   = i_q_lim;
                end
            end
            S_WAIT: begin
                n_state = S_DUMP;
                n_k     = '0;
            end
            S_DUMP: begin
                if (dump_step) begin
                    n_k = r_k + IW'(1);
                    if (k_last_hit) begin
                        n_state = S_COUNT;
                        n_init  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_COUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_DUMP;
            r_k        <= '0;
            r_lim      <= '0;
            r_init     <= 1'b1;
            r_b_valid  <= 1'b0;
            r_lw_valid <= 1'b0;
            r_pend     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_k        <= n_k;
            r_lim      <= n_lim;
            r_init     <= n_init;
            r_b_valid  <= cnt_rd;
            r_lw_valid <= cnt_we;
            r_pend     <= dump_rd;
            if (r_pend) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_b_addr    <= i_q_bin;
        r_lw_addr   <= r_b_addr;
        r_lw_data   <= incr;
        r_pend_k    <= r_k;
        r_pend_last <= ((LW'(r_k) + LW'(1)) == r_lim);
        if (r_pend) begin
            r_o_index <= r_pend_k;
            r_o_count <= ram_rdata;
            r_o_last  <= r_pend_last;
        end
    end

    vdrh_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign o_init      = r_init;
    assign o_valid     = r_o_valid;
    assign o_bin_index = r_o_index;
    assign o_bin_count = r_o_count;
    assign o_last_bin  = r_o_last;

`ifndef NO_ASSERTIONS
    a_pend_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> r_o_valid)
        else $error("bin read completed without a result");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |-> !r_pend)
        else $error("stalled result would be overwritten");
    a_update_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_state == S_COUNT || r_state == S_WAIT))
        else $error("bin update collides with the readout sweep");
    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !r_pend && !r_o_valid)
        else $error("result produced during the clearing sweep");
`endif

endmodule

[rtl/core/v_disparity_row_histogram.sv]
// Per-row disparity histogram (one row of a v-disparity image). Pixels arrive in raster
// order as unsigned fixed point with FRAC_BITS fraction bits; each is rounded half-up to
// a bin, and a nonzero bin below min(max_disp, NUM_BINS) is counted, saturating at
// MAX_WIDTH. The pixel flagged end_of_row is counted first, then bins 0 to limit-1 are
// sent in order, last_bin marking the final one, and all NUM_BINS bins are cleared.
// Within a row a pixel is taken every cycle while the queue has room: a four-entry queue
// feeds a histogram engine whose bin memory, with one read and one write port, does one
// read-modify-write per cycle. A row end keeps the engine from the next pixel while it
// does its own pop, lets its update land, then sweeps all NUM_BINS bins: the sweep
// lingers on each reported bin but the last, as only one bin read may be in flight,
// and every other bin is only cleared. Output stalls lengthen the sweep; pixels keep
// entering the queue until it is full. After reset the engine clears the bin memory,
// during which no pixel is taken; max_disp may be written meanwhile.
module v_disparity_row_histogram #(
    parameter int NUM_BINS  = vdrh_pkg::NUM_BINS_DEF,
    parameter int MAX_WIDTH = vdrh_pkg::MAX_WIDTH_DEF,
    parameter int FRAC_BITS = vdrh_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration.
    input  logic                           i_cfg_we,
    input  logic [vdrh_pkg::MAXD_W-1:0]    i_cfg_wdata,
    // Pixel requests.
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [vdrh_pkg::DISP_W-1:0]    i_disparity_q4,
    input  logic                           i_end_of_row,
    // Bin requests.
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [$clog2(NUM_BINS)-1:0]    o_bin_index,
    output logic [$clog2(MAX_WIDTH+1)-1:0] o_bin_count,
    output logic                           o_last_bin
);

    import vdrh_pkg::*;

    localparam int IW = $clog2(NUM_BINS);
    localparam int LW = $clog2(NUM_BINS + 1);
    localparam int MW = (LW > MAXD_W) ? LW : MAXD_W;

    logic [MAXD_W-1:0] r_max_disp;
    logic [LW-1:0]     lim;
    logic              init;
    logic              q_valid;
    logic              q_pop;
    logic [IW-1:0]     q_bin;
    logic              q_ok;
    logic              q_eor;
    logic [LW-1:0]     q_lim;

    // Bin-count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_disp <= MAXD_RESET;
        end else if (i_cfg_we) begin
            r_max_disp <= i_cfg_wdata;
        end
    end

    // Bins in use: the register, capped at the store size.
    assign lim = (MW'(r_max_disp) < MW'(NUM_BINS)) ? LW'(r_max_disp) : LW'(NUM_BINS);

    vdrh_front #(
        .NUM_BINS  (NUM_BINS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_disparity_q4 (i_disparity_q4),
        .i_end_of_row   (i_end_of_row),
        .i_lim          (lim),
        .i_init         (init),
        .o_q_valid      (q_valid),
        .i_q_pop        (q_pop),
        .o_q_bin        (q_bin),
        .o_q_ok         (q_ok),
        .o_q_eor        (q_eor),
        .o_q_lim        (q_lim)
    );

    vdrh_back #(
        .NUM_BINS  (NUM_BINS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_bin     (q_bin),
        .i_q_ok      (q_ok),
        .i_q_eor     (q_eor),
        .i_q_lim     (q_lim),
        .o_init      (init),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_bin_index (o_bin_index),
        .o_bin_count (o_bin_count),
        .o_last_bin  (o_last_bin)
    );

endmodule
